>>> hdl/bfa_pkg.sv
// Package for the best-fit block allocator.
// Holds shared constants, status and op codes and the sequencer state type.
// No dependencies.
package bfa_pkg;

  // Default parameter values
  localparam int MAX_BLOCKS_DEF   = 32;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int OFFSET_BITS_DEF  = 20;

  // Fixed field widths
  localparam int FIELD_BITS   = 20;
  localparam int PAYLOAD_BITS = 20;
  localparam int NEED_BITS    = PAYLOAD_BITS + 1;

  // Size rounding and split threshold
  localparam int SIZE_ALIGN        = 4;
  localparam int MIN_SPLIT_PAYLOAD = 4;

  // Region limits, one bit wider than the field for the rounding carry
  localparam logic [FIELD_BITS:0] PAGE_MASK  = (FIELD_BITS+1)'(4095);
  localparam logic [FIELD_BITS:0] REGION_MIN = (FIELD_BITS+1)'(4096);
  localparam logic [FIELD_BITS:0] REGION_MAX = (FIELD_BITS+1)'(1044480);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADADDR = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_SHRD = 8'b0000_1000,
    S_SHWR = 8'b0001_0000,
    S_FIN  = 8'b0010_0000,
    S_FIN2 = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

endpackage

>>> hdl/bfa_if.sv
// Channel interfaces of the best-fit block allocator: request, response, config.
// Depends on bfa_pkg for field widths.
interface bfa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [bfa_pkg::FIELD_BITS-1:0] request_size;
  logic [bfa_pkg::FIELD_BITS-1:0] block_address;
  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

interface bfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [bfa_pkg::FIELD_BITS-1:0] result_address;
  modport source (output valid, status, result_address, input ready);
  modport sink   (input valid, status, result_address, output ready);
endinterface

interface bfa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::FIELD_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/bfa_scan_unit.sv
// Shared compare unit: judges one table entry during a scan.
// Alloc: free, fits, smaller than best so far. Free: busy entry at the address.
// Depends on bfa_pkg.
module bfa_scan_unit #(
  parameter int OFFSET_BITS = bfa_pkg::OFFSET_BITS_DEF
) (
  input  logic                             op_i,
  input  logic [OFFSET_BITS-1:0]           start_i,
  input  logic [bfa_pkg::PAYLOAD_BITS-1:0] pay_i,
  input  logic                             busy_i,
  input  logic [bfa_pkg::NEED_BITS-1:0]    need_i,
  input  logic [bfa_pkg::FIELD_BITS-1:0]   addr_i,
  input  logic                             found_i,
  input  logic [bfa_pkg::PAYLOAD_BITS-1:0] best_pay_i,
  output logic                             take_o
);

  localparam int CMPW = (OFFSET_BITS > bfa_pkg::FIELD_BITS) ? OFFSET_BITS
                                                             : bfa_pkg::FIELD_BITS;

  logic fits, smaller, addr_hit;

  // Alloc test: payload >= need, strictly smaller keeps the lowest of equals
  assign fits     = {1'b0, pay_i} >= need_i;
  assign smaller  = !found_i || (pay_i < best_pay_i);
  assign addr_hit = CMPW'(start_i) == CMPW'(addr_i);

  always_comb begin
    if (op_i == bfa_pkg::OP_ALLOC) begin
      take_o = !busy_i && fits && smaller;
    end else begin
      take_o = busy_i && addr_hit && !found_i;
    end
  end

endmodule

>>> hdl/best_fit_block_allocator_core.sv
// Best-fit block allocator: sequencer, table RAM and shared compare unit.
// Depends on bfa_pkg, bfa_if, bfa_ram and bfa_scan_unit.
// Steps: a scan of the table, a read and a write per entry moved on a split or
// merge, 1-2 final writes on success, then the response; a zero-size alloc skips
// the scan and responds directly. Transactions are handled one at a time.
// Reset (async, active low) and every region write pass through S_INIT to write entry 0.
module best_fit_block_allocator_core #(
  parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF,
  parameter int OFFSET_BITS  = bfa_pkg::OFFSET_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o,
  bfa_cfg_if.sink   cfg_i
);

  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int OW  = OFFSET_BITS;
  localparam int PW  = bfa_pkg::PAYLOAD_BITS;
  localparam int NW  = bfa_pkg::NEED_BITS;
  localparam int FW  = bfa_pkg::FIELD_BITS;
  localparam int EW  = OW + PW + 1;
  localparam int SW  = ((OW > NW) ? OW : NW) + 2;
  localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] MINSP = SW'(bfa_pkg::MIN_SPLIT_PAYLOAD);
  localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE   = CW'(1);
  localparam logic [NW-1:0] ALGN  = NW'(bfa_pkg::SIZE_ALIGN - 1);

  bfa_pkg::state_e state_q, state_d;

  logic [FW-1:0] region_q, region_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          rv_q, rv_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic          op_q, op_d;
  logic [NW-1:0] need_q, need_d;
  logic [FW-1:0] addr_q, addr_d;
  logic          found_q, found_d;
  logic [CW-1:0] bidx_q, bidx_d;
  logic [OW-1:0] bstart_q, bstart_d;
  logic [PW-1:0] bpay_q, bpay_d;
  logic [OW-1:0] pstart_q, pstart_d;
  logic [PW-1:0] ppay_q, ppay_d;
  logic          pbusy_q, pbusy_d;
  logic [OW-1:0] lstart_q, lstart_d;
  logic [PW-1:0] lpay_q, lpay_d;
  logic          lbusy_q, lbusy_d;
  logic [PW-1:0] npay_q, npay_d;
  logic          nbusy_q, nbusy_d;
  logic          grab_q, grab_d;
  logic          split_q, split_d;
  logic          nf_q, nf_d;
  logic          pf_q, pf_d;
  logic [CW-1:0] src_q, src_d;
  logic [1:0]    status_q, status_d;
  logic [FW-1:0] res_q, res_d;
  logic          ovalid_q, ovalid_d;
  logic [1:0]    ostatus_q, ostatus_d;
  logic [FW-1:0] oaddr_q, oaddr_d;

  // Table RAM port signals
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [OW-1:0] re_start;
  logic [PW-1:0] re_pay;
  logic          re_busy;
  logic          take;

  // Helper values
  logic [FW:0]   cfg_round;
  logic [NW-1:0] req_need;
  logic [CW-1:0] rcnt;
  logic [SW-1:0] merged;

  assign {re_start, re_pay, re_busy} = rdata;

  bfa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bfa_scan_unit #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .op_i       (op_q),
    .start_i    (re_start),
    .pay_i      (re_pay),
    .busy_i     (re_busy),
    .need_i     (need_q),
    .addr_i     (addr_q),
    .found_i    (found_q),
    .best_pay_i (bpay_q),
    .take_o     (take)
  );

  // Region rounding, size rounding, merge sum
  assign cfg_round = ({1'b0, cfg_i.data} + bfa_pkg::PAGE_MASK) & ~bfa_pkg::PAGE_MASK;
  assign req_need  = ({1'b0, req_i.request_size} + ALGN) & ~ALGN;
  assign rcnt      = CW'(nf_q) + CW'(pf_q);
  assign merged    = SW'(bpay_q) + (nf_q ? (SW'(npay_q) + HDR) : '0)
                                 + (pf_q ? (SW'(ppay_q) + HDR) : '0);

  assign req_i.ready = (state_q == bfa_pkg::S_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = (state_q == bfa_pkg::S_IDLE);
  assign rsp_o.valid          = ovalid_q;
  assign rsp_o.status         = ostatus_q;
  assign rsp_o.result_address = oaddr_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    region_d  = region_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    rv_d      = 1'b0;
    ridx_d    = ridx_q;
    op_d      = op_q;
    need_d    = need_q;
    addr_d    = addr_q;
    found_d   = found_q;
    bidx_d    = bidx_q;
    bstart_d  = bstart_q;
    bpay_d    = bpay_q;
    pstart_d  = pstart_q;
    ppay_d    = ppay_q;
    pbusy_d   = pbusy_q;
    lstart_d  = lstart_q;
    lpay_d    = lpay_q;
    lbusy_d   = lbusy_q;
    npay_d    = npay_q;
    nbusy_d   = nbusy_q;
    grab_d    = grab_q;
    split_d   = split_q;
    nf_d      = nf_q;
    pf_d      = pf_q;
    src_d     = src_q;
    status_d  = status_q;
    res_d     = res_q;
    ovalid_d  = ovalid_q && !rsp_o.ready;
    ostatus_d = ostatus_q;
    oaddr_d   = oaddr_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;

    unique case (state_q)
      bfa_pkg::S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {OW'(0), PW'(SW'(region_q) - HDR), 1'b0};
        count_d = ONE;
        state_d = bfa_pkg::S_IDLE;
      end

      bfa_pkg::S_IDLE: begin
        if (cfg_i.valid) begin
          if (cfg_round < bfa_pkg::REGION_MIN) begin
            region_d = FW'(bfa_pkg::REGION_MIN);
          end else if (cfg_round > bfa_pkg::REGION_MAX) begin
            region_d = FW'(bfa_pkg::REGION_MAX);
          end else begin
            region_d = cfg_round[FW-1:0];
          end
          state_d = bfa_pkg::S_INIT;
        end else if (req_i.valid) begin
          op_d    = req_i.mode;
          need_d  = req_need;
          addr_d  = req_i.block_address;
          ptr_d   = '0;
          found_d = 1'b0;
          grab_d  = 1'b0;
          res_d   = '0;
          if (req_i.mode == bfa_pkg::OP_ALLOC && req_i.request_size == '0) begin
            status_d = bfa_pkg::ST_ZERO;
            state_d  = bfa_pkg::S_DONE;
          end else begin
            state_d = bfa_pkg::S_SCAN;
          end
        end
      end

      bfa_pkg::S_SCAN: begin
        // Issue reads in order; judge each returned entry in the cycle after its read
        raddr = ptr_q[IW-1:0];
        if (ptr_q < count_q) begin
          rv_d   = 1'b1;
          ridx_d = ptr_q;
          ptr_d  = ptr_q + ONE;
        end
        if (rv_q) begin
          lstart_d = re_start;
          lpay_d   = re_pay;
          lbusy_d  = re_busy;
          if (take) begin
            found_d  = 1'b1;
            bidx_d   = ridx_q;
            bstart_d = re_start;
            bpay_d   = re_pay;
            pstart_d = lstart_q;
            ppay_d   = lpay_q;
            pbusy_d  = lbusy_q;
            grab_d   = (op_q == bfa_pkg::OP_FREE);
          end else if (grab_q) begin
            npay_d  = re_pay;
            nbusy_d = re_busy;
            grab_d  = 1'b0;
          end
        end
        if (ptr_q == count_q && !rv_q) begin
          if (!found_q) begin
            status_d = (op_q == bfa_pkg::OP_ALLOC) ? bfa_pkg::ST_NOFIT : bfa_pkg::ST_BADADDR;
            state_d  = bfa_pkg::S_DONE;
          end else if (op_q == bfa_pkg::OP_ALLOC) begin
            status_d = bfa_pkg::ST_OK;
            res_d    = FW'(bstart_q);
            split_d  = (SW'(bpay_q) >= SW'(need_q) + HDR + MINSP) && (count_q < MAXC);
            src_d    = count_q - ONE;
            if ((SW'(bpay_q) >= SW'(need_q) + HDR + MINSP) && (count_q < MAXC)
                && (count_q > bidx_q + ONE)) begin
              state_d = bfa_pkg::S_SHRD;
            end else begin
              state_d = bfa_pkg::S_FIN;
            end
          end else begin
            status_d = bfa_pkg::ST_OK;
            nf_d     = (bidx_q + ONE < count_q) && !nbusy_q;
            pf_d     = (bidx_q != '0) && !pbusy_q;
            src_d    = bidx_q + ONE + CW'((bidx_q + ONE < count_q) && !nbusy_q);
            if ((((bidx_q + ONE < count_q) && !nbusy_q) || ((bidx_q != '0) && !pbusy_q))
                && (bidx_q + ONE + CW'((bidx_q + ONE < count_q) && !nbusy_q) < count_q)) begin
              state_d = bfa_pkg::S_SHRD;
            end else begin
              state_d = bfa_pkg::S_FIN;
            end
          end
        end
      end

      bfa_pkg::S_SHRD: begin
        raddr   = src_q[IW-1:0];
        state_d = bfa_pkg::S_SHWR;
      end

      bfa_pkg::S_SHWR: begin
        // Move one entry up (split) or down (merge)
        we    = 1'b1;
        wdata = rdata;
        if (op_q == bfa_pkg::OP_ALLOC) begin
          waddr = IW'(src_q + ONE);
          if (src_q == bidx_q + ONE) begin
            state_d = bfa_pkg::S_FIN;
          end else begin
            src_d   = src_q - ONE;
            state_d = bfa_pkg::S_SHRD;
          end
        end else begin
          waddr = IW'(src_q - rcnt);
          if (src_q == count_q - ONE) begin
            state_d = bfa_pkg::S_FIN;
          end else begin
            src_d   = src_q + ONE;
            state_d = bfa_pkg::S_SHRD;
          end
        end
      end

      bfa_pkg::S_FIN: begin
        we = 1'b1;
        if (op_q == bfa_pkg::OP_ALLOC) begin
          if (split_q) begin
            waddr   = IW'(bidx_q + ONE);
            wdata   = {OW'(SW'(bstart_q) + HDR + SW'(need_q)),
                       PW'(SW'(bpay_q) - SW'(need_q) - HDR), 1'b0};
            state_d = bfa_pkg::S_FIN2;
          end else begin
            waddr   = bidx_q[IW-1:0];
            wdata   = {bstart_q, bpay_q, 1'b1};
            state_d = bfa_pkg::S_DONE;
          end
        end else begin
          waddr   = pf_q ? IW'(bidx_q - ONE) : bidx_q[IW-1:0];
          wdata   = {pf_q ? pstart_q : bstart_q, PW'(merged), 1'b0};
          count_d = count_q - rcnt;
          state_d = bfa_pkg::S_DONE;
        end
      end

      bfa_pkg::S_FIN2: begin
        we      = 1'b1;
        waddr   = bidx_q[IW-1:0];
        wdata   = {bstart_q, PW'(need_q), 1'b1};
        count_d = count_q + ONE;
        state_d = bfa_pkg::S_DONE;
      end

      bfa_pkg::S_DONE: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          oaddr_d   = (status_q == bfa_pkg::ST_OK) ? res_q : '0;
          state_d   = bfa_pkg::S_IDLE;
        end
      end

      default: state_d = bfa_pkg::S_INIT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bfa_pkg::S_INIT;
      region_q <= FW'(bfa_pkg::REGION_MIN);
      count_q  <= ONE;
      ptr_q    <= '0;
      rv_q     <= 1'b0;
      found_q  <= 1'b0;
      grab_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      region_q <= region_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      rv_q     <= rv_d;
      found_q  <= found_d;
      grab_q   <= grab_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ridx_q    <= ridx_d;
    op_q      <= op_d;
    need_q    <= need_d;
    addr_q    <= addr_d;
    bidx_q    <= bidx_d;
    bstart_q  <= bstart_d;
    bpay_q    <= bpay_d;
    pstart_q  <= pstart_d;
    ppay_q    <= ppay_d;
    pbusy_q   <= pbusy_d;
    lstart_q  <= lstart_d;
    lpay_q    <= lpay_d;
    lbusy_q   <= lbusy_d;
    npay_q    <= npay_d;
    nbusy_q   <= nbusy_d;
    split_q   <= split_d;
    nf_q      <= nf_d;
    pf_q      <= pf_d;
    src_q     <= src_d;
    status_q  <= status_d;
    res_q     <= res_d;
    ostatus_q <= ostatus_d;
    oaddr_q   <= oaddr_d;
  end

endmodule

>>> hdl/bfa_checker.sv
// Port-level checker for the best-fit block allocator, bound to the top level.
// Depends on bfa_pkg and best_fit_block_allocator_core.
module bfa_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [19:0] rsp_addr_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // A stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
                                    && $stable(rsp_addr_i))
    else $error("response changed while stalled");

  // Failed requests report address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != bfa_pkg::ST_OK |-> rsp_addr_i == '0)
    else $error("nonzero address on failure");

  // One transaction at a time: busy right after accepting a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // Region write reinitializes the table before the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !req_ready_i && !cfg_ready_i)
    else $error("ready during table init");

endmodule

bind best_fit_block_allocator_core bfa_port_checker u_bfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_addr_i   (rsp_o.result_address),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready)
);

>>> verif/bfa_tb_if.sv
`timescale 1ns / 100ps
// Testbench view of the allocator channels: no extra interfaces needed here.
// The RTL interfaces in hdl/bfa_if.sv are used directly; this file holds the
// shared status-name helper used by the checker. Depends on bfa_pkg.
package bfa_tb_pkg;

  function automatic string status_name(logic [1:0] s);
    case (s)
      bfa_pkg::ST_OK:      return "OK";
      bfa_pkg::ST_NOFIT:   return "NOFIT";
      bfa_pkg::ST_ZERO:    return "ZERO";
      bfa_pkg::ST_BADADDR: return "BADADDR";
      default:             return "X";
    endcase
  endfunction
endpackage

>>> verif/bfa_checker.sv
`timescale 1ns / 100ps
// Checker for the best-fit allocator: watches request, response and config
// channels, keeps its own block table and compares every response.
// Depends on bfa_pkg, bfa_tb_pkg and the bfa_if interfaces.
module bfa_checker #(
  parameter int MAX_BLOCKS   = 32,
  parameter int HEADER_BYTES = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  bfa_req_if.sink req_m,
  bfa_rsp_if.sink rsp_m,
  bfa_cfg_if.sink cfg_m,
  output int      fail_count_o,
  output int      pending_o,
  output int      ok_allocs_o,
  output int      ok_frees_o
);
  import bfa_pkg::*;
  import bfa_tb_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [19:0] addr;
  } alloc_result_t;

  logic [19:0] tbl_start [MAX_BLOCKS];
  logic [19:0] tbl_size  [MAX_BLOCKS];
  logic        tbl_busy  [MAX_BLOCKS];
  int          tbl_used;
  alloc_result_t results_due[$];

  // Rebuild the table as one free block covering the region
  function automatic void table_clear(logic [19:0] raw);
    logic [20:0] r;
    r = ({1'b0, raw} + 21'd4095) & ~21'd4095;
    if (r < REGION_MIN) r = REGION_MIN;
    if (r > REGION_MAX) r = REGION_MAX;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      tbl_start[k] = '0;
      tbl_size[k]  = '0;
      tbl_busy[k]  = 1'b0;
    end
    tbl_size[0] = r[19:0] - 20'(HEADER_BYTES);
    tbl_used = 1;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < tbl_used; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_size[k]  = tbl_size[k+1];
      tbl_busy[k]  = tbl_busy[k+1];
    end
    tbl_used--;
    tbl_start[tbl_used] = '0;
    tbl_size[tbl_used]  = '0;
    tbl_busy[tbl_used]  = 1'b0;
  endfunction

  // Best-fit allocate with optional split
  function automatic alloc_result_t predict_alloc(logic [19:0] size);
    alloc_result_t res;
    logic [31:0] need;
    int best;
    best = -1;
    res = '{ST_OK, 20'd0};
    if (size == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    need = (32'(size) + 3) & ~32'd3;
    for (int i = 0; i < tbl_used; i++)
      if (!tbl_busy[i] && 32'(tbl_size[i]) >= need &&
          (best < 0 || tbl_size[i] < tbl_size[best])) best = i;
    if (best < 0) begin
      res.status = ST_NOFIT;
      return res;
    end
    if (32'(tbl_size[best]) >= need + HEADER_BYTES + 4 && tbl_used < MAX_BLOCKS) begin
      for (int i = tbl_used; i > best + 1; i--) begin
        tbl_start[i] = tbl_start[i-1];
        tbl_size[i]  = tbl_size[i-1];
        tbl_busy[i]  = tbl_busy[i-1];
      end
      tbl_start[best+1] = tbl_start[best] + 20'(HEADER_BYTES) + need[19:0];
      tbl_size[best+1]  = tbl_size[best] - need[19:0] - 20'(HEADER_BYTES);
      tbl_busy[best+1]  = 1'b0;
      tbl_size[best]    = need[19:0];
      tbl_used++;
    end
    tbl_busy[best] = 1'b1;
    res.addr = tbl_start[best];
    return res;
  endfunction

  // Release a busy block and merge with free neighbors
  function automatic alloc_result_t predict_free(logic [19:0] addr);
    alloc_result_t res;
    int idx;
    idx = -1;
    res = '{ST_OK, 20'd0};
    for (int i = 0; i < tbl_used; i++)
      if (idx < 0 && tbl_start[i] == addr && tbl_busy[i]) idx = i;
    if (idx < 0) begin
      res.status = ST_BADADDR;
      return res;
    end
    tbl_busy[idx] = 1'b0;
    if (idx + 1 < tbl_used && !tbl_busy[idx+1]) begin
      tbl_size[idx] += tbl_size[idx+1] + 20'(HEADER_BYTES);
      drop_entry(idx + 1);
    end
    if (idx > 0 && !tbl_busy[idx-1]) begin
      tbl_size[idx-1] += tbl_size[idx] + 20'(HEADER_BYTES);
      drop_entry(idx);
    end
    return res;
  endfunction

  assign pending_o = results_due.size();

  // Predict on each request transaction, compare on each response transaction
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      table_clear(20'd4096);
      results_due.delete();
      fail_count_o <= 0;
      ok_allocs_o  <= 0;
      ok_frees_o   <= 0;
    end else begin
      if (cfg_m.valid && cfg_m.ready) table_clear(cfg_m.data);
      if (req_m.valid && req_m.ready) begin
        if (req_m.mode == OP_ALLOC) begin
          want = predict_alloc(req_m.request_size);
          if (want.status == ST_OK) ok_allocs_o <= ok_allocs_o + 1;
        end else begin
          want = predict_free(req_m.block_address);
          if (want.status == ST_OK) ok_frees_o <= ok_frees_o + 1;
        end
        results_due.push_back(want);
      end
      if (rsp_m.valid && rsp_m.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected response status=%s addr=%h", $time,
                   status_name(rsp_m.status), rsp_m.result_address);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = results_due.pop_front();
          if (rsp_m.status !== want.status || rsp_m.result_address !== want.addr) begin
            $display("%0t: mismatch expected status=%s addr=%h actual status=%s addr=%h",
                     $time, status_name(want.status), want.addr,
                     status_name(rsp_m.status), rsp_m.result_address);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_best_fit_block_allocator_core.sv
`timescale 1ns / 100ps
// Top of the allocator regression: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, bfa_tb_pkg, bfa_if, bfa_checker and the core.
module tb_best_fit_block_allocator_core;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, ok_allocs, ok_frees;
  int   configs_done;
  logic [19:0] live_addrs[$];

  bfa_req_if req_if ();
  bfa_rsp_if rsp_if ();
  bfa_cfg_if cfg_if ();

  best_fit_block_allocator_core dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if), .cfg_i(cfg_if)
  );

  bfa_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_m(req_if), .rsp_m(rsp_if), .cfg_m(cfg_if),
    .fail_count_o(fail_count), .pending_o(pending),
    .ok_allocs_o(ok_allocs), .ok_frees_o(ok_frees)
  );

  initial forever #4 clk_i = ~clk_i;

  // Run limit, far beyond the slowest legal run
  initial begin
    #40ms;
    $display("best_fit_block_allocator_core regression: fail");
    $finish;
  end

  // Receiver stall pattern: phases of no stall, light and heavy stall
  initial begin
    int phase;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      phase = int'(($time / 20000) % 3);
      case (phase)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(3) != 0);
        default: rsp_if.ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // Track live blocks from the response channel so frees hit real headers
  logic last_mode;
  always @(posedge clk_i)
    if (req_if.valid && req_if.ready) last_mode <= req_if.mode;

  task automatic send_item(logic mode, logic [19:0] size, logic [19:0] addr);
    req_if.valid         <= 1'b1;
    req_if.mode          <= mode;
    req_if.request_size  <= size;
    req_if.block_address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    // one item in flight: wait for its response so live list stays exact
    while (pending != 0) @(negedge clk_i);
  endtask

  // Response monitor filling the list of live headers
  always @(posedge clk_i)
    if (rsp_if.valid && rsp_if.ready && rsp_if.status == bfa_pkg::ST_OK
        && rsp_if.result_address != 0)
      live_addrs.push_back(rsp_if.result_address);
    else if (rsp_if.valid && rsp_if.ready && rsp_if.status == bfa_pkg::ST_OK
             && last_mode == bfa_pkg::OP_ALLOC)
      live_addrs.push_back(20'd0);

  task automatic idle_gap();
    repeat ($urandom_range(6)) @(negedge clk_i);
  endtask

  task automatic write_region(logic [19:0] value);
    repeat (200) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    live_addrs.delete();
    configs_done++;
  endtask

  task automatic free_some();
    int k;
    if (live_addrs.size() == 0) return;
    k = $urandom_range(live_addrs.size() - 1);
    send_item(bfa_pkg::OP_FREE, 20'($urandom), live_addrs[k]);
    live_addrs.delete(k);
  endtask

  logic [19:0] regions[6] = '{20'd0, 20'hFFFFF, 20'd4097, 20'd8192, 20'd1044480, 20'd4096};

  initial begin
    int burst_left;
    burst_left = 0;
    req_if.valid = 1'b0; req_if.mode = bfa_pkg::OP_ALLOC;
    req_if.request_size = '0; req_if.block_address = '0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    configs_done = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // Directed: zero size, odd sizes, exact fit, no fit, bad and repeat frees
    send_item(bfa_pkg::OP_ALLOC, 20'd0, 20'hFFFFF);
    send_item(bfa_pkg::OP_ALLOC, 20'd1, 20'd0);
    send_item(bfa_pkg::OP_ALLOC, 20'd5, 20'd0);
    send_item(bfa_pkg::OP_ALLOC, 20'hFFFFF, 20'd0);
    send_item(bfa_pkg::OP_FREE, 20'hFFFFF, 20'hFFFFF);
    send_item(bfa_pkg::OP_FREE, 20'd0, 20'd8);
    send_item(bfa_pkg::OP_FREE, 20'd0, 20'd8);
    send_item(bfa_pkg::OP_ALLOC, 20'd6, 20'd0);      // best fit splits the free tail block
    send_item(bfa_pkg::OP_FREE, 20'd0, 20'd0);
    send_item(bfa_pkg::OP_FREE, 20'd0, 20'd16);
    send_item(bfa_pkg::OP_ALLOC, 20'd4088, 20'd0);   // whole-region size: no fit while blocks are busy
    send_item(bfa_pkg::OP_FREE, 20'd0, 20'd0);
    send_item(bfa_pkg::OP_ALLOC, 20'd4077, 20'd0);   // 4080 after rounding: no fit
    send_item(bfa_pkg::OP_FREE, 20'd0, 20'd0);
    // fill the table to force the no-split path
    live_addrs.delete();
    repeat (34) send_item(bfa_pkg::OP_ALLOC, 20'd4, 20'd0);
    while (live_addrs.size() > 0) free_some();

    // Random phases over several region settings, sent in bursts with gaps
    for (int p = 0; p < 6; p++) begin
      write_region(p == 5 ? 20'($urandom) : regions[p]);
      for (int n = 0; n < 250; n++) begin
        if (burst_left == 0) begin
          idle_gap();
          burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        case ($urandom_range(9))
          0: send_item(bfa_pkg::OP_ALLOC, 20'($urandom), 20'($urandom));
          1: send_item(bfa_pkg::OP_FREE, 20'($urandom), 20'($urandom));
          2, 3, 4: free_some();
          5: send_item(bfa_pkg::OP_ALLOC, 20'($urandom_range(4096)), 20'($urandom));
          default: send_item(bfa_pkg::OP_ALLOC, 20'($urandom_range(64)), 20'($urandom));
        endcase
      end
    end

    repeat (200) @(negedge clk_i);
    $display("Covered %0d region settings, %0d good allocs, %0d good frees.",
             configs_done, ok_allocs, ok_frees);
    if (fail_count == 0 && pending == 0)
      $display("best_fit_block_allocator_core regression: pass");
    else
      $display("best_fit_block_allocator_core regression: fail");
    $finish;
  end
endmodule
